// File: hw/rtl/ctlfu_pkg.sv
// Connection table package: field widths, register codes, reset values,
// the table entry layout and the controller state type.
// Used by ctlfu_top logic in connection_table_lfu_top.
`timescale 1ns / 1ps

package ctlfu_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ADDR_W       = 48;
    localparam int USES_W       = 32;
    localparam int MAXE_W       = 5;
    localparam int CFG_IDX_W    = 1;

    localparam logic [USES_W-1:0] USES_MAX        = '1;
    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RST = 5'd10;
    localparam logic              REJECT_RST      = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REJECT_FULL = 1'b1;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] side_a;
        logic [ADDR_W-1:0] side_b;
        logic [USES_W-1:0] uses;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

endpackage

// File: hw/rtl/connection_table_lfu_top.sv
// Connection table with least-frequently-used replacement; needs ctlfu_pkg, ctlfu_ram.
// A new request is taken only in the idle state, after the last one has gone through
// the slot-by-slot scan of the single-port entry RAM (one read per cycle), then the
// decide and write-back step, which waits while the output is stalled, and back to idle.
// Reset: synchronous, active low; a clearing pass over every slot then zeroes the RAM,
// during which requests are stalled and configuration writes are still taken.
`timescale 1ns / 1ps

module connection_table_lfu_top
    import ctlfu_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MAXE_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_action,
    input  logic [ADDR_W-1:0]    i_side_a_addr,
    input  logic [ADDR_W-1:0]    i_side_b_addr,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_found,
    output logic [USES_W-1:0]    o_use_count,
    output logic                 o_rejected
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int LW = (OW > MAXE_W) ? OW : MAXE_W;
    localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_idx;
    logic [OW-1:0]       r_occ;
    logic [MAXE_W-1:0]   r_max_entries;
    logic                r_reject;

    logic                r_act;
    logic [ADDR_W-1:0]   r_a, r_b;
    logic                r_hit, r_free_ok, r_min_ok;
    logic [AW-1:0]       r_hit_idx, r_free_idx, r_min_idx;
    logic [USES_W-1:0]   r_hit_uses, r_min_uses;

    logic                r_out_valid;
    logic                r_found, r_rejected;
    logic [USES_W-1:0]   r_count;

    logic                w_we;
    logic [AW-1:0]       w_addr;
    logic [ENTRY_W-1:0]  w_wdata, w_rdata;
    t_entry              w_rd, w_wentry;

    logic                w_accept, w_emit, w_full, w_write, w_occ_inc;
    logic                w_found, w_rej, w_match;
    logic [LW-1:0]       w_lim;
    logic [AW-1:0]       w_target;
    logic [USES_W-1:0]   w_new_uses, w_count;

    ctlfu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    assign w_rd     = t_entry'(w_rdata);
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_emit   = (r_state == S_DECIDE) && (!r_out_valid || !i_out_stall);
    assign w_match  = w_rd.valid && (w_rd.side_a == r_a) && (w_rd.side_b == r_b);

    always_comb begin
        w_lim = LW'(r_max_entries);
        if (w_lim == '0) begin
            w_lim = LW'(1);
        end
        if (w_lim > LW'(CAPACITY)) begin
            w_lim = LW'(CAPACITY);
        end
    end

    assign w_full     = LW'(r_occ) >= w_lim;
    assign w_new_uses = (r_hit_uses == USES_MAX) ? r_hit_uses : r_hit_uses + USES_W'(1);

    always_comb begin
        w_write   = 1'b0;
        w_occ_inc = 1'b0;
        w_found   = 1'b0;
        w_rej     = 1'b0;
        w_count   = '0;
        w_target  = r_free_idx;
        w_wentry  = '{valid: 1'b1, side_a: r_a, side_b: r_b, uses: USES_W'(1)};
        if (r_hit) begin
            w_write        = 1'b1;
            w_found        = 1'b1;
            w_count        = w_new_uses;
            w_target       = r_hit_idx;
            w_wentry.uses  = w_new_uses;
        end else if (r_act == ACT_INSERT) begin
            if (w_full && r_reject) begin
                w_rej = 1'b1;
            end else if (w_full && r_min_ok) begin
                w_write  = 1'b1;
                w_count  = USES_W'(1);
                w_target = r_min_idx;
            end else if (r_free_ok) begin
                w_write   = 1'b1;
                w_occ_inc = 1'b1;
                w_count   = USES_W'(1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_idx == LAST) n_state = S_IDLE;
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (r_idx == LAST) n_state = S_DECIDE;
            S_DECIDE: if (w_emit) n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_we       = 1'b0;
        w_addr     = '0;
        w_wdata    = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_we   = 1'b1;
                w_addr = r_idx;
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_SCAN: begin
                w_addr = r_idx + AW'(1);
            end
            S_DECIDE: begin
                w_we    = w_write && w_emit;
                w_addr  = w_target;
                w_wdata = w_wentry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_idx         <= '0;
            r_occ         <= '0;
            r_max_entries <= MAX_ENTRIES_RST;
            r_reject      <= REJECT_RST;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data;
                    CFG_REJECT_FULL: r_reject      <= i_cfg_data[0];
                endcase
            end
            if (r_state == S_CLEAR || r_state == S_SCAN) begin
                r_idx <= (r_idx == LAST) ? '0 : r_idx + AW'(1);
            end else if (w_accept) begin
                r_idx <= '0;
            end
            if (w_emit && w_occ_inc) begin
                r_occ <= r_occ + OW'(1);
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act     <= i_action;
            r_a       <= i_side_a_addr;
            r_b       <= i_side_b_addr;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_min_ok  <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (w_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_idx;
                r_hit_uses <= w_rd.uses;
            end
            if (!w_rd.valid && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (w_rd.valid && (!r_min_ok || w_rd.uses < r_min_uses)) begin
                r_min_ok   <= 1'b1;
                r_min_idx  <= r_idx;
                r_min_uses <= w_rd.uses;
            end
        end
        if (w_emit) begin
            r_found    <= w_found;
            r_rejected <= w_rej;
            r_count    <= w_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_use_count = r_count;
    assign o_rejected  = r_rejected;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(CAPACITY))
        else $error("occupancy above capacity");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rejected) |-> (!o_found && o_use_count == '0))
        else $error("rejected request reports a hit or a count");

    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_use_count != '0))
        else $error("hit reports zero count");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN && r_idx == '0))
        else $error("accepted request did not start a scan");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || w_emit))
        else $error("RAM write outside clear or write-back");

endmodule

// File: hw/rtl/ctlfu_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ctlfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for connection_table_lfu_top: a directed table of requests,
// then random table traffic, scored against a table model in this file or, for typed
// rows, the row's expected result. Depends on ctlfu_pkg and the connection table RTL.
`timescale 1ns / 1ps

module tb_top;
    import ctlfu_pkg::*;

    localparam int IDLE_PCT   = 27;
    localparam int PHASES     = 7;
    localparam int PHASE_REQS = 250;
    localparam int KEY_POOL   = 24;
    localparam int MAX_CYCLES = 500000;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        logic              found;
        logic [USES_W-1:0] count;
        logic              rejected;
    } t_result;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [MAXE_W-1:0]    data;
        logic                 act;
        logic [ADDR_W-1:0]    a;
        logic [ADDR_W-1:0]    b;
        logic                 typed;
        t_result              exp;
    } t_row;

    localparam logic [ADDR_W-1:0] A_ZERO = '0;
    localparam logic [ADDR_W-1:0] A_ONES = '1;
    localparam logic [ADDR_W-1:0] A_ALT1 = 48'hAAAA_AAAA_AAAA;
    localparam logic [ADDR_W-1:0] A_ALT0 = 48'h5555_5555_5555;
    localparam logic [ADDR_W-1:0] A_ONE  = 48'd1;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MAXE_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_action;
    logic [ADDR_W-1:0]    i_side_a_addr;
    logic [ADDR_W-1:0]    i_side_b_addr;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_found;
    logic [USES_W-1:0]    o_use_count;
    logic                 o_rejected;

    // table model state
    logic              conn_valid [CAPACITY_DEF];
    logic [ADDR_W-1:0] conn_a     [CAPACITY_DEF];
    logic [ADDR_W-1:0] conn_b     [CAPACITY_DEF];
    logic [USES_W-1:0] conn_uses  [CAPACITY_DEF];
    int unsigned       conn_count;
    logic [MAXE_W-1:0] limit_reg;
    logic              reject_reg;

    t_result     pending_results[$];
    t_row        request_table[$];
    logic        row_typed;
    t_result     row_exp;
    logic        steady;
    int unsigned error_count;
    int unsigned cycle_count;

    connection_table_lfu_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_side_a_addr (i_side_a_addr),
        .i_side_b_addr (i_side_b_addr),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_use_count   (o_use_count),
        .o_rejected    (o_rejected)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_result predict_access(logic act, logic [ADDR_W-1:0] a,
                                               logic [ADDR_W-1:0] b);
        t_result     res;
        int          hit;
        int          target;
        int unsigned lim;
        res = '0;
        hit = -1;
        target = -1;
        lim = (limit_reg == 0) ? 1 : limit_reg;
        if (lim > CAPACITY_DEF) lim = CAPACITY_DEF;
        for (int i = 0; i < CAPACITY_DEF; i++) begin
            if (hit < 0 && conn_valid[i] && conn_a[i] == a && conn_b[i] == b) hit = i;
        end
        if (hit >= 0) begin
            if (conn_uses[hit] != USES_MAX) conn_uses[hit] = conn_uses[hit] + 1;
            res.found = 1'b1;
            res.count = conn_uses[hit];
        end else if (act == ACT_INSERT) begin
            if (conn_count >= lim && reject_reg) begin
                res.rejected = 1'b1;
            end else begin
                if (conn_count >= lim) begin
                    for (int i = 0; i < CAPACITY_DEF; i++) begin
                        if (conn_valid[i] && (target < 0 || conn_uses[i] < conn_uses[target]))
                            target = i;
                    end
                    if (target >= 0) conn_count--;
                end
                if (target < 0) begin
                    for (int i = CAPACITY_DEF - 1; i >= 0; i--) begin
                        if (!conn_valid[i]) target = i;
                    end
                end
                if (target >= 0) begin
                    conn_valid[target] = 1'b1;
                    conn_a[target] = a;
                    conn_b[target] = b;
                    conn_uses[target] = 1;
                    conn_count++;
                    res.count = 1;
                end
            end
        end
        return res;
    endfunction

    task automatic flag_error(string what, t_result want, t_result got);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("ERROR %0t: %s: expected found=%0d count=%0d rejected=%0d,",
                     $time, what, want.found, want.count, want.rejected,
                     " got found=%0d count=%0d rejected=%0d",
                     got.found, got.count, got.rejected);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        cycle_count++;
        if (cycle_count > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MAX_ENTRIES) limit_reg = i_cfg_data;
                else if (i_cfg_index == CFG_REJECT_FULL) reject_reg = i_cfg_data[0];
            end
            if (i_in_valid && !o_in_stall) begin
                want = predict_access(i_action, i_side_a_addr, i_side_b_addr);
                if (row_typed) want = row_exp;
                pending_results.push_back(want);
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{found: o_found, count: o_use_count, rejected: o_rejected};
                if (pending_results.size() == 0) begin
                    flag_error("result with no request outstanding", '0, got);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) flag_error("result differs", want, got);
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (steady) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < IDLE_PCT);
    end

    task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [MAXE_W-1:0] data);
        t_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.data = data;
        request_table.push_back(r);
    endtask

    task automatic add_req(logic act, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                           logic typed, logic f, logic [USES_W-1:0] c, logic rej);
        t_row r;
        r = '{default: '0};
        r.act = act;
        r.a = a;
        r.b = b;
        r.typed = typed;
        r.exp = '{found: f, count: c, rejected: rej};
        request_table.push_back(r);
    endtask

    // entered and left at a falling edge
    task automatic send_request(logic act, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b,
                                logic typed, t_result exp);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_side_a_addr <= a;
        i_side_b_addr <= b;
        row_typed <= typed;
        row_exp <= exp;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MAXE_W-1:0] data);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [ADDR_W-1:0] pool_a [KEY_POOL];
        logic [ADDR_W-1:0] pool_b [KEY_POOL];
        logic [MAXE_W-1:0] phase_limit [PHASES];
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [ADDR_W-1:0] swap;
        logic              act;
        int                k;
        t_row              r;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_MAX_ENTRIES;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_action = ACT_INSERT;
        i_side_a_addr = '0;
        i_side_b_addr = '0;
        i_out_stall = 1'b0;
        row_typed = 1'b0;
        row_exp = '0;
        steady = 1'b0;
        error_count = 0;
        cycle_count = 0;
        conn_count = 0;
        limit_reg = MAX_ENTRIES_RST;
        reject_reg = REJECT_RST;
        for (int i = 0; i < CAPACITY_DEF; i++) begin
            conn_valid[i] = 1'b0;
            conn_a[i] = '0;
            conn_b[i] = '0;
            conn_uses[i] = '0;
        end

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_cfg(CFG_MAX_ENTRIES, 5'd2);
        add_cfg(CFG_REJECT_FULL, 5'd1);
        add_req(ACT_LOOKUP, A_ZERO, A_ZERO, 1'b1, 1'b0, 0, 1'b0);
        add_req(ACT_INSERT, A_ZERO, A_ZERO, 1'b1, 1'b0, 1, 1'b0);
        add_req(ACT_INSERT, A_ONES, A_ONES, 1'b1, 1'b0, 1, 1'b0);
        add_req(ACT_INSERT, A_ZERO, A_ZERO, 1'b1, 1'b1, 2, 1'b0);
        add_req(ACT_INSERT, A_ONE,  A_ZERO, 1'b1, 1'b0, 0, 1'b1);
        add_req(ACT_LOOKUP, A_ONES, A_ONES, 1'b1, 1'b1, 2, 1'b0);
        add_req(ACT_INSERT, A_ONES, A_ONES, 1'b1, 1'b1, 3, 1'b0);
        add_cfg(CFG_REJECT_FULL, 5'd0);
        add_req(ACT_INSERT, A_ZERO, A_ONES, 1'b0, 1'b0, 0, 1'b0);
        add_req(ACT_LOOKUP, A_ZERO, A_ZERO, 1'b1, 1'b0, 0, 1'b0);
        add_req(ACT_INSERT, A_ONES, A_ZERO, 1'b0, 1'b0, 0, 1'b0);
        add_req(ACT_LOOKUP, A_ZERO, A_ONES, 1'b1, 1'b0, 0, 1'b0);
        add_cfg(CFG_MAX_ENTRIES, 5'd0);
        add_req(ACT_INSERT, A_ALT1, A_ALT0, 1'b0, 1'b0, 0, 1'b0);
        add_req(ACT_LOOKUP, A_ONES, A_ONES, 1'b0, 1'b0, 0, 1'b0);
        add_req(ACT_LOOKUP, A_ALT1, A_ALT0, 1'b0, 1'b0, 0, 1'b0);
        add_req(ACT_LOOKUP, A_ALT0, A_ALT1, 1'b1, 1'b0, 0, 1'b0);
        add_cfg(CFG_MAX_ENTRIES, 5'd31);
        add_cfg(CFG_REJECT_FULL, 5'd1);
        add_req(ACT_INSERT, A_ALT0, A_ALT1, 1'b0, 1'b0, 0, 1'b0);
        add_req(ACT_INSERT, A_ONE,  A_ZERO, 1'b0, 1'b0, 0, 1'b0);
        add_req(ACT_LOOKUP, A_ONE,  A_ZERO, 1'b0, 1'b0, 0, 1'b0);

        foreach (request_table[i]) begin
            r = request_table[i];
            if (r.is_cfg) write_reg(r.idx, r.data);
            else send_request(r.act, r.a, r.b, r.typed, r.exp);
        end

        phase_limit = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd12, 5'd0};
        phase_limit[PHASES-1] = $urandom_range(31);
        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_MAX_ENTRIES, phase_limit[p]);
            if (p == PHASES - 1) write_reg(CFG_REJECT_FULL, MAXE_W'($urandom_range(1)));
            else write_reg(CFG_REJECT_FULL, MAXE_W'(~p & 1));
            for (int i = 0; i < KEY_POOL; i++) begin
                pool_a[i] = ADDR_W'({$urandom, $urandom});
                pool_b[i] = ADDR_W'({$urandom, $urandom});
            end
            pool_a[0] = A_ONES;
            pool_b[1] = A_ZERO;
            steady = (p == 3);
            for (int n = 0; n < PHASE_REQS; n++) begin
                if ($urandom_range(99) < 80) begin
                    k = $urandom_range(KEY_POOL - 1);
                    a = pool_a[k];
                    b = pool_b[k];
                    if ($urandom_range(9) == 0) begin
                        swap = a;
                        a = b;
                        b = swap;
                    end
                end else begin
                    a = ADDR_W'({$urandom, $urandom});
                    b = ADDR_W'({$urandom, $urandom});
                end
                act = ($urandom_range(99) < 60) ? ACT_INSERT : ACT_LOOKUP;
                send_request(act, a, b, 1'b0, '0);
            end
            steady = 1'b0;
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (3 * CAPACITY_DEF) @(negedge i_clk);
        error_count += pending_results.size();
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
